// ===== hw/rtl/ladsr_pkg.sv =====
package ladsr_pkg;

	// Number formats of the datapath
	localparam int SAMPLE_BITS   = 16;
	localparam int FRACTION_BITS = 16;
	localparam int TIME_BITS     = 24;
	localparam int LEVEL_BITS    = SAMPLE_BITS + FRACTION_BITS;
	localparam int SPAN_BITS     = SAMPLE_BITS + 1;
	localparam int DIVIDEND_BITS = SPAN_BITS + FRACTION_BITS;
	localparam int STEP_BITS     = DIVIDEND_BITS;
	localparam int NEXT_BITS     = STEP_BITS + 2;
	localparam int DIV_CNT_BITS  = $clog2(DIVIDEND_BITS + 1);
	localparam int PHASE_BITS    = 3;

	// Input item layout, first field in the lowest bits
	localparam int GATE_LSB     = 0;
	localparam int AT_LSB       = GATE_LSB + SAMPLE_BITS;
	localparam int AL_LSB       = AT_LSB + TIME_BITS;
	localparam int DT_LSB       = AL_LSB + SAMPLE_BITS;
	localparam int SL_LSB       = DT_LSB + TIME_BITS;
	localparam int RT_LSB       = SL_LSB + SAMPLE_BITS;
	localparam int RL_LSB       = RT_LSB + TIME_BITS;
	localparam int IN_USED_BITS = RL_LSB + SAMPLE_BITS;
	localparam int IN_TDATA_BITS = ((IN_USED_BITS + 7) / 8) * 8;

	// Result item layout
	localparam int ENV_LSB        = 0;
	localparam int PHASE_LSB      = ENV_LSB + SAMPLE_BITS;
	localparam int OUT_USED_BITS  = PHASE_LSB + PHASE_BITS;
	localparam int OUT_TDATA_BITS = ((OUT_USED_BITS + 7) / 8) * 8;

	// Configuration port
	localparam int APB_ADDR_BITS = 3;
	localparam int APB_DATA_BITS = 32;
	localparam logic REG_GATE_THRESHOLD = 1'b0;
	localparam logic signed [SAMPLE_BITS-1:0] THRESHOLD_RESET = 16'sd6554;

	// Envelope stages
	localparam logic [PHASE_BITS-1:0] PH_ATTACK   = 3'd0;
	localparam logic [PHASE_BITS-1:0] PH_DECAY    = 3'd1;
	localparam logic [PHASE_BITS-1:0] PH_SUSTAIN  = 3'd2;
	localparam logic [PHASE_BITS-1:0] PH_RELEASE  = 3'd3;
	localparam logic [PHASE_BITS-1:0] PH_FINISHED = 3'd4;

	// Bound on stage changes within one sample
	localparam int GUARD_STEPS = 8;
	localparam int GUARD_BITS  = $clog2(GUARD_STEPS);

	// Divider request and response
	typedef struct packed {
		logic                     start;
		logic [DIVIDEND_BITS-1:0] dividend;
		logic [TIME_BITS-1:0]     divisor;
	} div_req_t;

	typedef struct packed {
		logic                 done;
		logic [STEP_BITS-1:0] quotient;
	} div_rsp_t;

endpackage

// ===== hw/rtl/ladsr_regs.sv =====
module ladsr_regs (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   psel,
	input  logic                                   penable,
	input  logic                                   pwrite,
	input  logic [ladsr_pkg::APB_ADDR_BITS-1:0]    paddr,
	input  logic [ladsr_pkg::APB_DATA_BITS-1:0]    pwdata,
	output logic [ladsr_pkg::APB_DATA_BITS-1:0]    prdata,
	output logic                                   pready,
	output logic signed [ladsr_pkg::SAMPLE_BITS-1:0] threshold
);
	import ladsr_pkg::*;

	logic signed [SAMPLE_BITS-1:0] threshold_q;
	logic                          wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	// Gate threshold register, written in the access phase of a transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RESET;
		end else if (wr_en && (paddr[2] == REG_GATE_THRESHOLD)) begin
			threshold_q <= pwdata[SAMPLE_BITS-1:0];
		end
	end

	// Read data, sign extended to the bus width.
	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_GATE_THRESHOLD) begin
			prdata = APB_DATA_BITS'(threshold_q);
		end
	end

	assign threshold = threshold_q;

endmodule

// ===== hw/rtl/ladsr_div.sv =====
module ladsr_div (
	input  logic                clk,
	input  logic                arst_n,
	input  ladsr_pkg::div_req_t req,
	output ladsr_pkg::div_rsp_t rsp
);
	import ladsr_pkg::*;

	logic                     busy_q;
	logic                     done_q;
	logic [DIV_CNT_BITS-1:0]  cnt_q;
	logic [DIVIDEND_BITS-1:0] dq_q;
	logic [TIME_BITS-1:0]     rem_q;
	logic [TIME_BITS-1:0]     divisor_q;
	logic [TIME_BITS:0]       shifted;
	logic [TIME_BITS+1:0]     trial;

	// One quotient bit per cycle: bring down the next dividend bit and try a subtract.
	assign shifted = {rem_q, dq_q[DIVIDEND_BITS-1]};
	assign trial   = {1'b0, shifted} - {2'b00, divisor_q};

	// Bit counter and completion pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= DIV_CNT_BITS'(DIVIDEND_BITS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - DIV_CNT_BITS'(1);
			if (cnt_q == DIV_CNT_BITS'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Dividend shifts out at the top while quotient bits shift in at the bottom.
	always_ff @(posedge clk) begin
		if (req.start) begin
			dq_q      <= req.dividend;
			rem_q     <= '0;
			divisor_q <= req.divisor;
		end else if (busy_q) begin
			if (!trial[TIME_BITS+1]) begin
				rem_q <= trial[TIME_BITS-1:0];
				dq_q  <= {dq_q[DIVIDEND_BITS-2:0], 1'b1};
			end else begin
				rem_q <= shifted[TIME_BITS-1:0];
				dq_q  <= {dq_q[DIVIDEND_BITS-2:0], 1'b0};
			end
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = dq_q;

endmodule

// ===== hw/rtl/linear_adsr_envelope.sv =====
// Each ramp step divides on the bit-serial divider (one quotient bit per cycle, 33 bits).
// The block takes no new item until the previous one is worked through to the result register;
// a finished result may wait while the next item is worked.
// Reset (asynchronous, active low): stage attack, level zero, threshold 6554.
module linear_adsr_envelope (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// gate, attack_time, attack_level, decay_time, sustain_level,
	// release_time, release_level (lowest bit first)
	input  logic [ladsr_pkg::IN_TDATA_BITS-1:0]   s_tdata,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// envelope, phase, zero padding (lowest bit first)
	output logic [ladsr_pkg::OUT_TDATA_BITS-1:0]  m_tdata,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [ladsr_pkg::APB_ADDR_BITS-1:0]   paddr,
	input  logic [ladsr_pkg::APB_DATA_BITS-1:0]   pwdata,
	output logic [ladsr_pkg::APB_DATA_BITS-1:0]   prdata,
	output logic                                  pready
);
	import ladsr_pkg::*;

	// Sequencer states
	localparam logic [2:0] SQ_IDLE = 3'd0;
	localparam logic [2:0] SQ_EVAL = 3'd1;
	localparam logic [2:0] SQ_DIV  = 3'd2;
	localparam logic [2:0] SQ_ADD  = 3'd3;
	localparam logic [2:0] SQ_CMP  = 3'd4;
	localparam logic [2:0] SQ_OUT  = 3'd5;
	localparam logic [GUARD_BITS-1:0] GUARD_LAST = GUARD_BITS'(GUARD_STEPS - 1);

	logic signed [SAMPLE_BITS-1:0] threshold;
	div_req_t                      div_req;
	div_rsp_t                      div_rsp;

	logic [2:0]                    state_q;
	logic [PHASE_BITS-1:0]         stage_q;
	logic signed [LEVEL_BITS-1:0]  level_q;
	logic [GUARD_BITS-1:0]         guard_q;
	logic                          m_tvalid_q;

	logic signed [SAMPLE_BITS-1:0] gate_q;
	logic [TIME_BITS-1:0]          at_q;
	logic signed [SAMPLE_BITS-1:0] al_q;
	logic [TIME_BITS-1:0]          dt_q;
	logic signed [SAMPLE_BITS-1:0] sl_q;
	logic [TIME_BITS-1:0]          rt_q;
	logic signed [SAMPLE_BITS-1:0] rl_q;
	logic signed [SAMPLE_BITS-1:0] target_q;
	logic [PHASE_BITS-1:0]         next_stage_q;
	logic signed [NEXT_BITS-1:0]   nxt_q;
	logic                          up_q;
	logic [SAMPLE_BITS-1:0]        env_q;
	logic [PHASE_BITS-1:0]         phase_q;

	logic signed [SAMPLE_BITS-1:0] sel_target;
	logic signed [SAMPLE_BITS-1:0] sel_origin;
	logic [TIME_BITS-1:0]          sel_time;
	logic [PHASE_BITS-1:0]         sel_next;
	logic signed [SPAN_BITS-1:0]   span_diff;
	logic [SPAN_BITS-1:0]          span_mag;
	logic                          gate_lt;
	logic                          gate_gt;
	logic                          adv_needed;
	logic                          time_zero;
	logic [2:0]                    cont_state;
	logic signed [LEVEL_BITS-1:0]  sel_target_lvl;
	logic signed [LEVEL_BITS-1:0]  target_lvl;
	logic signed [NEXT_BITS-1:0]   level_ext;
	logic signed [NEXT_BITS-1:0]   step_ext;
	logic signed [NEXT_BITS-1:0]   target_ext;
	logic                          reached;

	ladsr_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.threshold (threshold)
	);

	ladsr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Ramp parameters of the current stage: target, origin, time and successor.
	always_comb begin
		case (stage_q)
			PH_ATTACK: begin
				sel_target = al_q;
				sel_origin = rl_q;
				sel_time   = at_q;
				sel_next   = PH_DECAY;
			end
			PH_DECAY: begin
				sel_target = sl_q;
				sel_origin = al_q;
				sel_time   = dt_q;
				sel_next   = PH_SUSTAIN;
			end
			default: begin
				sel_target = rl_q;
				sel_origin = sl_q;
				sel_time   = rt_q;
				sel_next   = PH_FINISHED;
			end
		endcase
	end

	// Gate decisions and whether this stage step ramps the level.
	assign gate_lt = gate_q < threshold;
	assign gate_gt = gate_q > threshold;
	always_comb begin
		case (stage_q)
			PH_ATTACK: adv_needed = 1'b1;
			PH_DECAY:  adv_needed = !gate_lt;
			PH_RELEASE: adv_needed = !gate_gt;
			default:   adv_needed = 1'b0;
		endcase
	end
	assign time_zero = (sel_time == '0);

	// Span of the ramp, scaled to the level format, goes to the divider.
	assign span_diff = SPAN_BITS'(sel_target) - SPAN_BITS'(sel_origin);
	assign span_mag  = span_diff[SPAN_BITS-1] ? SPAN_BITS'(-span_diff) : span_diff;
	assign div_req.start    = (state_q == SQ_EVAL) && adv_needed && !time_zero;
	assign div_req.dividend = {span_mag, {FRACTION_BITS{1'b0}}};
	assign div_req.divisor  = sel_time;

	// Level arithmetic of a ramp step, widened so the sum cannot wrap.
	assign sel_target_lvl = {sel_target, {FRACTION_BITS{1'b0}}};
	assign target_lvl     = {target_q, {FRACTION_BITS{1'b0}}};
	assign level_ext      = NEXT_BITS'(level_q);
	assign step_ext       = $signed({2'b00, div_rsp.quotient});
	assign target_ext     = NEXT_BITS'(target_lvl);
	assign reached        = up_q ? (nxt_q >= target_ext) : (nxt_q <= target_ext);

	// Another stage step in the same sample, unless the step bound is used up.
	assign cont_state = (guard_q == GUARD_LAST) ? SQ_OUT : SQ_EVAL;

	// Sequencer, stage and level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= SQ_IDLE;
			stage_q    <= PH_ATTACK;
			level_q    <= '0;
			guard_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			// The output state reloads the result register itself.
			if (m_tvalid_q && m_tready && (state_q != SQ_OUT)) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				SQ_IDLE: begin
					if (s_tvalid) begin
						state_q <= SQ_EVAL;
						guard_q <= '0;
					end
				end
				SQ_EVAL: begin
					if (adv_needed) begin
						if (time_zero) begin
							level_q <= sel_target_lvl;
							stage_q <= sel_next;
							state_q <= cont_state;
							guard_q <= guard_q + GUARD_BITS'(1);
						end else begin
							state_q <= SQ_DIV;
						end
					end else begin
						case (stage_q)
							PH_DECAY: begin
								stage_q <= PH_RELEASE;
								state_q <= cont_state;
								guard_q <= guard_q + GUARD_BITS'(1);
							end
							PH_SUSTAIN: begin
								if (gate_lt) begin
									stage_q <= PH_RELEASE;
									state_q <= cont_state;
									guard_q <= guard_q + GUARD_BITS'(1);
								end else begin
									level_q <= {sl_q, {FRACTION_BITS{1'b0}}};
									state_q <= SQ_OUT;
								end
							end
							PH_RELEASE: begin
								stage_q <= PH_ATTACK;
								state_q <= cont_state;
								guard_q <= guard_q + GUARD_BITS'(1);
							end
							default: begin
								if (gate_gt) begin
									stage_q <= PH_ATTACK;
									state_q <= cont_state;
									guard_q <= guard_q + GUARD_BITS'(1);
								end else begin
									stage_q <= PH_FINISHED;
									level_q <= {rl_q, {FRACTION_BITS{1'b0}}};
									state_q <= SQ_OUT;
								end
							end
						endcase
					end
				end
				SQ_DIV: begin
					if (div_rsp.done) begin
						state_q <= SQ_ADD;
					end
				end
				SQ_ADD: begin
					state_q <= SQ_CMP;
				end
				SQ_CMP: begin
					if (reached) begin
						level_q <= target_lvl;
						stage_q <= next_stage_q;
						state_q <= cont_state;
						guard_q <= guard_q + GUARD_BITS'(1);
					end else begin
						level_q <= nxt_q[LEVEL_BITS-1:0];
						state_q <= SQ_OUT;
					end
				end
				SQ_OUT: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						state_q    <= SQ_IDLE;
					end
				end
				default: begin
					state_q <= SQ_IDLE;
				end
			endcase
		end
	end

	// Item capture, ramp operands and the result register.
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			gate_q <= s_tdata[GATE_LSB +: SAMPLE_BITS];
			at_q   <= s_tdata[AT_LSB +: TIME_BITS];
			al_q   <= s_tdata[AL_LSB +: SAMPLE_BITS];
			dt_q   <= s_tdata[DT_LSB +: TIME_BITS];
			sl_q   <= s_tdata[SL_LSB +: SAMPLE_BITS];
			rt_q   <= s_tdata[RT_LSB +: TIME_BITS];
			rl_q   <= s_tdata[RL_LSB +: SAMPLE_BITS];
		end
		if (div_req.start) begin
			target_q     <= sel_target;
			next_stage_q <= sel_next;
		end
		if (state_q == SQ_ADD) begin
			up_q  <= (target_lvl >= level_q);
			nxt_q <= (target_lvl >= level_q) ? (level_ext + step_ext) : (level_ext - step_ext);
		end
		if ((state_q == SQ_OUT) && (!m_tvalid_q || m_tready)) begin
			// Arithmetic shift gives the floor of the level.
			env_q   <= level_q[LEVEL_BITS-1:FRACTION_BITS];
			phase_q <= stage_q;
		end
	end

	assign s_tready = (state_q == SQ_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = OUT_TDATA_BITS'({phase_q, env_q});

endmodule

// ===== hw/rtl/ladsr_checker.sv =====
module ladsr_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 s_tvalid,
	input logic                                 s_tready,
	input logic [ladsr_pkg::OUT_TDATA_BITS-1:0] m_tdata,
	input logic                                 m_tvalid,
	input logic                                 m_tready
);
	import ladsr_pkg::*;

	// A stalled result transfer keeps its data.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// The phase is always one of the five stages.
	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[PHASE_LSB +: PHASE_BITS] <= PH_FINISHED))
		else $error("phase out of range");

	// The padding above the phase stays zero.
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[OUT_TDATA_BITS-1:OUT_USED_BITS] == '0))
		else $error("padding bits set");

	// One item at a time: the input is closed in the cycle after a transfer.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input open while an item is in work");

endmodule

bind linear_adsr_envelope ladsr_checker u_ladsr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tdata  (m_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready)
);
